### design/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants of the sliding window median filter
// Sample, result and port widths, controller states and the cell chain control and status.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int SAMPLE_W           = 32;
  localparam int RESULT_W           = 33;
  localparam int WSIZE_W            = 7;
  localparam int OUT_TDATA_W        = 40;
  localparam int WINDOW_MAX_DEFAULT = 64;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FEED,
    ST_DRAIN,
    ST_UNLOAD,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    MODE_CLEAR,
    MODE_INSERT,
    MODE_SHIFT,
    MODE_HOLD
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
  } chain_ctrl_t;

  typedef struct packed {
    logic busy;        // a value is still moving along the chain
    logic head_valid;  // first cell holds a value
  } chain_stat_t;

endpackage

### design/swm_cell.sv
// ----------------------------------------------------------------------------
// swm_cell: one compare-and-pass cell of the sorting chain
// Keeps the smaller of its held value and the incoming value, passes the
// larger one to the right neighbor through a register; shifts left on unload.
// ----------------------------------------------------------------------------
module swm_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  swm_pkg::chain_ctrl_t ctrl,
  input  logic                 in_valid,
  input  swm_pkg::sample_t     in_val,
  input  logic                 right_valid,
  input  swm_pkg::sample_t     right_val,
  output logic                 held_valid,
  output swm_pkg::sample_t     held_val,
  output logic                 out_valid,
  output swm_pkg::sample_t     out_val
);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      unique case (ctrl.mode)
        swm_pkg::MODE_CLEAR: begin
          held_valid <= 1'b0;
          out_valid  <= 1'b0;
        end
        swm_pkg::MODE_INSERT: begin
          if (in_valid) begin
            if (!held_valid) begin
              held_valid <= 1'b1;
              held_val   <= in_val;
              out_valid  <= 1'b0;
            end else if (in_val < held_val) begin
              // take the smaller value, push the old one right
              held_val  <= in_val;
              out_valid <= 1'b1;
              out_val   <= held_val;
            end else begin
              out_valid <= 1'b1;
              out_val   <= in_val;
            end
          end else begin
            out_valid <= 1'b0;
          end
        end
        swm_pkg::MODE_SHIFT: begin
          held_valid <= right_valid;
          held_val   <= right_val;
          out_valid  <= 1'b0;
        end
        swm_pkg::MODE_HOLD: begin
          held_valid <= held_valid;
          out_valid  <= out_valid;
        end
        default: begin
          held_valid <= held_valid;
          out_valid  <= out_valid;
        end
      endcase
    end
  end

endmodule

### design/swm_chain.sv
// ----------------------------------------------------------------------------
// swm_chain: row of sorting cells
// Values enter at the first cell and settle in ascending order from the
// head; an unload shifts the row toward the head one place per cycle.
// ----------------------------------------------------------------------------
module swm_chain #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  swm_pkg::chain_ctrl_t ctrl,
  input  logic                 feed_valid,
  input  swm_pkg::sample_t     feed_val,
  output swm_pkg::sample_t     head_val,
  output swm_pkg::chain_stat_t stat
);

  logic             held_valid [WINDOW_MAX];
  swm_pkg::sample_t held_val   [WINDOW_MAX];
  logic             out_valid  [WINDOW_MAX];
  swm_pkg::sample_t out_val    [WINDOW_MAX];
  logic [WINDOW_MAX-1:0] out_valid_vec;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic             c_in_valid;
    swm_pkg::sample_t c_in_val;
    logic             c_right_valid;
    swm_pkg::sample_t c_right_val;

    if (i == 0) begin : g_first
      assign c_in_valid = feed_valid;
      assign c_in_val   = feed_val;
    end else begin : g_mid
      assign c_in_valid = out_valid[i-1];
      assign c_in_val   = out_val[i-1];
    end

    if (i == WINDOW_MAX - 1) begin : g_last
      assign c_right_valid = 1'b0;
      assign c_right_val   = '0;
    end else begin : g_inner
      assign c_right_valid = held_valid[i+1];
      assign c_right_val   = held_val[i+1];
    end

    swm_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .in_valid    (c_in_valid),
      .in_val      (c_in_val),
      .right_valid (c_right_valid),
      .right_val   (c_right_val),
      .held_valid  (held_valid[i]),
      .held_val    (held_val[i]),
      .out_valid   (out_valid[i]),
      .out_val     (out_val[i])
    );

    assign out_valid_vec[i] = out_valid[i];
  end

  assign head_val        = held_val[0];
  assign stat.busy       = |out_valid_vec;
  assign stat.head_valid = held_valid[0];

endmodule

### design/sliding_window_median_core.sv
// ----------------------------------------------------------------------------
// sliding_window_median_core: sliding window median filter
// Streaming median of the newest K signed samples, result doubled.
// ----------------------------------------------------------------------------
// Each input beat carries one signed 32-bit sample in tdata and a start flag
// in tuser that opens a new sequence. Once K samples of the sequence have
// arrived (K is window_size, 0 read as 1, capped at WINDOW_MAX), every beat
// yields twice the median of the K newest samples as a 33-bit signed value.
// A beat that yields no result leaves the core ready for the next beat. For a
// beat with a result, the K newest samples are read from the sample ring
// one per cycle through its single read port and settle in the cell chain,
// and shifts toward the head then bring the middle values there. The input
// stays blocked during that work; a finished result waits in the output
// register while the next beat is taken.
module sliding_window_median_core #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              window_size_we,
  input  logic [swm_pkg::WSIZE_W-1:0]       window_size_wdata,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [swm_pkg::SAMPLE_W-1:0]      s_axis_tdata,  // [31:0] sample
  input  logic                              s_axis_tuser,  // [0] start_req
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [swm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata   // [32:0] median_doubled
);

  localparam int KW = $clog2(WINDOW_MAX + 1);
  localparam int PW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam logic [KW-1:0] KMAX = KW'(WINDOW_MAX);
  localparam logic [PW-1:0] PLAST = PW'(WINDOW_MAX - 1);

  swm_pkg::state_t       state, state_next;
  swm_pkg::chain_ctrl_t  ctrl;
  swm_pkg::chain_stat_t  stat;

  logic [swm_pkg::WSIZE_W-1:0] window_size;
  swm_pkg::sample_t            ring [WINDOW_MAX];
  logic [PW-1:0]               write_position;
  logic [KW-1:0]               fill_count;
  logic [KW-1:0]               k_cur, k_reg;
  logic [KW-1:0]               fill_base, fill_new;
  logic                        need_result, accept;
  logic [PW-1:0]               rd_addr;
  swm_pkg::sample_t            rd_data;
  logic                        feed_valid;
  logic [KW-1:0]               feed_cnt, unl_cnt, half;
  swm_pkg::sample_t            mid_lo, mid_hi;
  swm_pkg::sample_t            head_val;
  logic                        out_free;

  // Effective window
  always_comb begin
    if (window_size == '0) begin
      k_cur = KW'(1);
    end else if ({{(32-swm_pkg::WSIZE_W){1'b0}}, window_size} > 32'(WINDOW_MAX)) begin
      k_cur = KMAX;
    end else begin
      k_cur = KW'(window_size);
    end
  end

  assign accept      = s_axis_tvalid && s_axis_tready;
  assign fill_base   = s_axis_tuser ? '0 : fill_count;
  assign fill_new    = (fill_base < KMAX) ? fill_base + KW'(1) : fill_base;
  assign need_result = fill_new >= k_cur;
  assign half        = k_reg >> 1;
  assign out_free    = !m_axis_tvalid || m_axis_tready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      swm_pkg::ST_IDLE:   if (accept && need_result) state_next = swm_pkg::ST_FEED;
      swm_pkg::ST_FEED:   if (feed_cnt == k_reg - KW'(1)) state_next = swm_pkg::ST_DRAIN;
      swm_pkg::ST_DRAIN:  if (!feed_valid && !stat.busy) state_next = swm_pkg::ST_UNLOAD;
      swm_pkg::ST_UNLOAD: if (unl_cnt == half) state_next = swm_pkg::ST_DONE;
      swm_pkg::ST_DONE:   if (out_free) state_next = swm_pkg::ST_IDLE;
      default:            state_next = swm_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the controller
  always_comb begin
    s_axis_tready = 1'b0;
    ctrl.mode     = swm_pkg::MODE_HOLD;
    unique case (state)
      swm_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        ctrl.mode     = swm_pkg::MODE_CLEAR;
      end
      swm_pkg::ST_FEED:   ctrl.mode = swm_pkg::MODE_INSERT;
      swm_pkg::ST_DRAIN:  ctrl.mode = swm_pkg::MODE_INSERT;
      swm_pkg::ST_UNLOAD: ctrl.mode = swm_pkg::MODE_SHIFT;
      swm_pkg::ST_DONE:   ctrl.mode = swm_pkg::MODE_HOLD;
      default:            ctrl.mode = swm_pkg::MODE_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= swm_pkg::WSIZE_W'(1);
    end else if (window_size_we) begin
      window_size <= window_size_wdata;
    end
  end

  // Sample ring
  always_ff @(posedge clk) begin
    if (accept) begin
      ring[write_position] <= s_axis_tdata;
    end
    if (state == swm_pkg::ST_FEED) begin
      rd_data <= ring[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_position <= '0;
      fill_count     <= '0;
      feed_valid     <= 1'b0;
    end else begin
      feed_valid <= (state == swm_pkg::ST_FEED);
      if (accept) begin
        write_position <= (write_position == PLAST) ? '0 : write_position + PW'(1);
        fill_count     <= fill_new;
        k_reg          <= k_cur;
        rd_addr        <= write_position;
        feed_cnt       <= '0;
        unl_cnt        <= '0;
      end
      if (state == swm_pkg::ST_FEED) begin
        // walk back through the newest samples
        rd_addr  <= (rd_addr == '0) ? PLAST : rd_addr - PW'(1);
        feed_cnt <= feed_cnt + KW'(1);
      end
      if (state == swm_pkg::ST_UNLOAD) begin
        if (unl_cnt == half) begin
          mid_hi <= head_val;
          if (k_reg[0]) mid_lo <= head_val;
        end else begin
          if (unl_cnt == half - KW'(1)) mid_lo <= head_val;
          unl_cnt <= unl_cnt + KW'(1);
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else begin
      if (state == swm_pkg::ST_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= {{(swm_pkg::OUT_TDATA_W-swm_pkg::RESULT_W){1'b0}},
                          {mid_lo[swm_pkg::SAMPLE_W-1], mid_lo} +
                          {mid_hi[swm_pkg::SAMPLE_W-1], mid_hi}};
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  swm_chain #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_chain (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .feed_valid (feed_valid),
    .feed_val   (rd_data),
    .head_val   (head_val),
    .stat       (stat)
  );

  // Chain must have settled before any shift toward the head
  a_unload_settled: assert property (@(posedge clk) disable iff (rst)
    (state == swm_pkg::ST_UNLOAD) |-> !stat.busy)
    else $error("chain still moving during unload");

  // The middle value is always a real sample
  a_head_valid: assert property (@(posedge clk) disable iff (rst)
    (state == swm_pkg::ST_UNLOAD && unl_cnt == half) |-> stat.head_valid)
    else $error("empty cell reached the head at the median position");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= KMAX)
    else $error("fill count beyond window maximum");

  a_feed_bound: assert property (@(posedge clk) disable iff (rst)
    (state == swm_pkg::ST_FEED) |-> (feed_cnt < k_reg))
    else $error("more samples fed than the window holds");

  a_result_start: assert property (@(posedge clk) disable iff (rst)
    (accept && need_result) |=> (state == swm_pkg::ST_FEED))
    else $error("accepted beat with a due result did not start the sort");

endmodule

### test/sliding_window_median_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sliding_window_median_core_tb: self-checking bench of the median filter
// Streams signed samples with start flags through several window sizes,
// predicts twice the median of the newest K samples per beat and checks each
// output beat in order against that prediction under random back-pressure.
// ----------------------------------------------------------------------------
module sliding_window_median_core_tb;

  localparam int               WMAX          = swm_pkg::WINDOW_MAX_DEFAULT;
  localparam int               RANDOM_ITEMS  = 1400;
  localparam int               SETTLE_CYCLES = 200;   // outlasts the longest busy stretch of the core
  localparam int               CYCLE_LIMIT   = 2_000_000;
  localparam int               MAX_REPORTS   = 10;
  localparam swm_pkg::sample_t SMP_MAX       = 32'sh7FFF_FFFF;
  localparam swm_pkg::sample_t SMP_MIN       = 32'sh8000_0000;

  logic                            clk;
  logic                            rst;
  logic                            window_size_we;
  logic [swm_pkg::WSIZE_W-1:0]     window_size_wdata;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [swm_pkg::SAMPLE_W-1:0]    s_axis_tdata;   // [31:0] sample
  logic                            s_axis_tuser;   // [0] start_req
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [swm_pkg::OUT_TDATA_W-1:0] m_axis_tdata;   // [32:0] median_doubled

  // predictor state
  swm_pkg::sample_t                     hist_ring [WMAX];
  logic [5:0]                           wr_ptr;
  int                                   fill_cnt;
  logic [swm_pkg::WSIZE_W-1:0]          win_reg;
  logic signed [swm_pkg::RESULT_W-1:0]  median_q [$];

  int src_idle_pct;
  int snk_idle_pct;
  int errors;
  int cycle_cnt;

  sliding_window_median_core i_dut (
    .clk               (clk),
    .rst               (rst),
    .window_size_we    (window_size_we),
    .window_size_wdata (window_size_wdata),
    .s_axis_tvalid     (s_axis_tvalid),
    .s_axis_tready     (s_axis_tready),
    .s_axis_tdata      (s_axis_tdata),
    .s_axis_tuser      (s_axis_tuser),
    .m_axis_tvalid     (m_axis_tvalid),
    .m_axis_tready     (m_axis_tready),
    .m_axis_tdata      (m_axis_tdata)
  );

  always #5 clk = ~clk;

  function automatic int eff_window(input logic [swm_pkg::WSIZE_W-1:0] ws);
    if (ws == 0) return 1;
    if (ws > WMAX) return WMAX;
    return int'(ws);
  endfunction

  // Store one accepted sample and queue twice the window median, if any.
  task automatic track_sample(input swm_pkg::sample_t smp, input bit start);
    swm_pkg::sample_t                    win [WMAX];
    swm_pkg::sample_t                    v;
    logic [5:0]                          idx;
    logic signed [swm_pkg::RESULT_W-1:0] med;
    int                                  k;
    int                                  i;
    int                                  j;
    if (start) fill_cnt = 0;
    hist_ring[wr_ptr] = smp;
    wr_ptr = wr_ptr + 6'd1;
    if (fill_cnt < WMAX) fill_cnt++;
    k = eff_window(win_reg);
    if (fill_cnt < k) return;
    for (i = 0; i < k; i++) begin
      idx = wr_ptr - 6'(i) - 6'd1;
      v = hist_ring[idx];
      j = i;
      while (j > 0 && win[j-1] > v) begin
        win[j] = win[j-1];
        j--;
      end
      win[j] = v;
    end
    if (k % 2 == 1)
      med = {win[k/2], 1'b0};
    else
      med = $signed({win[k/2-1][swm_pkg::SAMPLE_W-1], win[k/2-1]}) +
            $signed({win[k/2][swm_pkg::SAMPLE_W-1], win[k/2]});
    median_q = {median_q, med};
  endtask

  // Drive one beat, with random idle cycles ahead of it, and wait for it.
  task automatic send_sample(input swm_pkg::sample_t smp, input bit start);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tuser  <= start;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    track_sample(smp, start);
  endtask

  // Drop valid, let every expected beat come out, then let the core settle.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (median_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [swm_pkg::WSIZE_W-1:0] ws);
    window_size_we    <= 1'b1;
    window_size_wdata <= ws;
    @(posedge clk);
    window_size_we    <= 1'b0;
    win_reg = ws;
  endtask

  function automatic swm_pkg::sample_t rand_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 3))
        0:       return SMP_MIN;
        1:       return SMP_MAX;
        2:       return -32'sd1;
        default: return 32'sd0;
      endcase
    end
    // narrow range gives duplicates and negative half medians
    if (r <= 3) return swm_pkg::sample_t'($urandom_range(0, 16)) - 32'sd8;
    return swm_pkg::sample_t'($urandom);
  endfunction

  // Window of one after reset: every beat echoes its sample doubled.
  task automatic test_reset_window();
    send_sample(SMP_MAX, 1'b1);
    send_sample(SMP_MIN, 1'b0);
    send_sample(-32'sd1, 1'b0);
    send_sample(32'sd0, 1'b0);
  endtask

  // Even window over the extremes reaches both output limits.
  task automatic test_output_extremes();
    wait_idle();
    write_window(7'd2);
    send_sample(SMP_MAX, 1'b1);
    send_sample(SMP_MAX, 1'b0);
    send_sample(SMP_MIN, 1'b0);
    send_sample(SMP_MIN, 1'b0);
  endtask

  task automatic test_window_zero();
    wait_idle();
    write_window(7'd0);
    send_sample(32'sd17, 1'b0);
    send_sample(-32'sd5, 1'b0);
  endtask

  task automatic test_odd_window();
    wait_idle();
    write_window(7'd3);
    send_sample(-32'sd3, 1'b1);
    send_sample(32'sd5, 1'b0);
    send_sample(-32'sd1, 1'b0);
    send_sample(32'sd7, 1'b0);
    send_sample(-32'sd7, 1'b0);
  endtask

  // Grow the window mid-sequence: results pause until the fill catches up.
  task automatic test_window_growth();
    wait_idle();
    write_window(7'd8);
    send_sample(-32'sd2, 1'b0);
    send_sample(-32'sd3, 1'b0);
    send_sample(32'sd4, 1'b0);
    send_sample(SMP_MIN, 1'b0);
  endtask

  // Start flag mid-stream clears the fill but not the ring position.
  task automatic test_restart();
    wait_idle();
    write_window(7'd2);
    send_sample(32'sd9, 1'b1);
    send_sample(-32'sd4, 1'b0);
    send_sample(32'sd1, 1'b1);
  endtask

  task automatic test_random_stream();
    int                          sent;
    int                          len;
    int                          k;
    int                          n;
    int                          r;
    bit                          fresh;
    logic [swm_pkg::WSIZE_W-1:0] ws;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case (sent * 3 / RANDOM_ITEMS)
        0:       begin src_idle_pct = 24; snk_idle_pct = 64; end
        1:       begin src_idle_pct = 64; snk_idle_pct = 24; end
        default: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
      endcase
      r = $urandom_range(0, 99);
      if (r < 60)      ws = 7'($urandom_range(1, 8));
      else if (r < 80) ws = 7'($urandom_range(9, 20));
      else if (r < 88) ws = 7'($urandom_range(21, 64));
      else if (r < 92) ws = 7'd64;
      else if (r < 96) ws = 7'd0;
      else             ws = 7'($urandom_range(65, 127));
      wait_idle();
      write_window(ws);
      k = eff_window(ws);
      // mostly fresh sequences; otherwise keep the fill across the change
      fresh = ($urandom_range(0, 99) < 80);
      len = (k > 20) ? k + $urandom_range(0, 8) : k + $urandom_range(0, 30);
      for (n = 0; n < len; n++)
        send_sample(rand_sample(), (n == 0 && fresh) || ($urandom_range(0, 99) < 3));
      sent += len;
    end
  endtask

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    logic signed [swm_pkg::RESULT_W-1:0] exp_med;
    logic signed [swm_pkg::RESULT_W-1:0] got_med;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_med = $signed(m_axis_tdata[swm_pkg::RESULT_W-1:0]);
      if (median_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected median beat: got %0d", got_med);
      end else begin
        exp_med = median_q.pop_front();
        if (got_med !== exp_med) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("median mismatch: expected %0d got %0d", exp_med, got_med);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    clk               = 1'b0;
    rst               = 1'b1;
    window_size_we    = 1'b0;
    window_size_wdata = '0;
    s_axis_tvalid     = 1'b0;
    s_axis_tdata      = '0;
    s_axis_tuser      = 1'b0;
    m_axis_tready     = 1'b0;
    wr_ptr            = '0;
    fill_cnt          = 0;
    win_reg           = 7'd1;
    src_idle_pct      = 24;
    snk_idle_pct      = 64;
    errors            = 0;
    cycle_cnt         = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_window();
    test_output_extremes();
    test_window_zero();
    test_odd_window();
    test_window_growth();
    test_restart();
    test_random_stream();

    wait_idle();
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
